// ===== design/wlr_pkg.sv =====
// Shared constants and types for the window/level ramp table unit.
// Register indexes, reset values and the entry-class code live here.
// No dependencies.
package wlr_pkg;

    // Default table depth handed to the top-level parameter
    localparam int WLR_MAX_COLORS_DEF = 256;

    // Configuration port geometry
    localparam int WLR_CFG_AW = 3;
    localparam int WLR_CFG_DW = 32;

    // Fixed field widths
    localparam int WLR_IDX_W   = 8;
    localparam int WLR_RGBA_W  = 32;
    localparam int WLR_COUNT_W = 9;
    localparam int WLR_GRAY_W  = 8;

    // Smallest usable table size and the ramp alpha
    localparam int                    WLR_MIN_COLORS   = 2;
    localparam logic [WLR_GRAY_W-1:0] WLR_OPAQUE_ALPHA = 8'hFF;
    localparam int                    WLR_GRAY_SCALE   = 510;

    // Register reset values
    localparam logic signed [31:0]          WLR_LEVEL_RST   = 32'sd8388608;
    localparam logic [30:0]                 WLR_WINDOW_RST  = 31'd16777216;
    localparam logic signed [31:0]          WLR_RLOW_RST    = 32'sd0;
    localparam logic signed [31:0]          WLR_RHIGH_RST   = 32'sd65536;
    localparam logic [WLR_COUNT_W-1:0]      WLR_COUNT_RST   = 9'd256;
    localparam logic [WLR_RGBA_W-1:0]       WLR_BELOW_RST   = 32'hFF00_0000;
    localparam logic [WLR_RGBA_W-1:0]       WLR_ABOVE_RST   = 32'hFFFF_FFFF;

    // Configuration register indexes
    typedef enum logic [WLR_CFG_AW-1:0] {
        CFG_LEVEL       = 3'd0,
        CFG_WINDOW      = 3'd1,
        CFG_RANGE_LOW   = 3'd2,
        CFG_RANGE_HIGH  = 3'd3,
        CFG_COLOR_COUNT = 3'd4,
        CFG_INVERSE     = 3'd5,
        CFG_BELOW_COLOR = 3'd6,
        CFG_ABOVE_COLOR = 3'd7
    } cfg_reg_t;

    // Where an entry falls relative to the ramp
    typedef enum logic [1:0] {
        SEL_LO   = 2'd0,
        SEL_HI   = 2'd1,
        SEL_RAMP = 2'd2
    } sel_t;

endpackage

// ===== design/window_level_ramp_table_unit.sv =====
// Window/level ramp table unit: maps a table entry index to its RGBA color.
// Depends on wlr_pkg, wlr_div_cell and wlr_skid.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one entry index per word.
//   Master stream (m_tvalid/m_tready/m_tdata) returns one RGBA word per index,
//   in order. The config port (cfg_we/cfg_addr/cfg_data) writes one register
//   per cycle; write it only while no word is in flight.
// Path: an accepted index passes stage 1, stage 2, the index division cells,
//   stage 3, stage 4, the gray division cells and the output register.
// Throughput: one word per cycle while not stalled. The ramp ends come from
//   two lanes of IW+1 restoring-division cells, IW = clog2(MAX_COLORS), one
//   quotient bit per cell; the gray level from a further row of 8 cells. Each
//   word carries its own division, so a new index enters each unstalled cycle.
// Reset: configuration registers take their documented reset values, the
//   pipeline empties, and s_tready is already high at the first clock after reset.
// Stall: the output register plus one skid slot absorb a stalled receiver;
//   once the skid slot is full the whole pipeline holds and s_tready drops.
module window_level_ramp_table_unit
    import wlr_pkg::*;
#(
    parameter int MAX_COLORS = WLR_MAX_COLORS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Entry index stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] entry_index
    // Color stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [7:0] red, [15:8] green,
                                              // [23:16] blue, [31:24] alpha
    // Register writes
    input  logic                   cfg_we,
    input  logic [WLR_CFG_AW-1:0]  cfg_addr,
    input  logic [WLR_CFG_DW-1:0]  cfg_data
);

    localparam int IW    = $clog2(MAX_COLORS);
    localparam int CW    = $clog2(MAX_COLORS + 1);
    localparam int QW    = IW + 1;
    localparam int XW    = (CW > WLR_COUNT_W) ? CW : WLR_COUNT_W;
    localparam int XIW   = (IW > WLR_IDX_W) ? IW : WLR_IDX_W;
    localparam int AW    = 35;
    localparam int DIFFW = 33;
    localparam int DENW  = DIFFW + 1;
    localparam int NUMW  = AW + CW + 1;
    localparam int RW    = NUMW - 1;
    localparam int ESW   = CW + 1;
    localparam int GW    = IW + 9;
    localparam int GDW   = IW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0]     level_reg;
    logic [30:0]            window_reg;
    logic signed [31:0]     range_low_reg;
    logic signed [31:0]     range_high_reg;
    logic [WLR_COUNT_W-1:0] color_count_reg;
    logic                   inverse_reg;
    logic [WLR_RGBA_W-1:0]  below_reg;
    logic [WLR_RGBA_W-1:0]  above_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= WLR_LEVEL_RST;
            window_reg      <= WLR_WINDOW_RST;
            range_low_reg   <= WLR_RLOW_RST;
            range_high_reg  <= WLR_RHIGH_RST;
            color_count_reg <= WLR_COUNT_RST;
            inverse_reg     <= 1'b0;
            below_reg       <= WLR_BELOW_RST;
            above_reg       <= WLR_ABOVE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_LEVEL:       level_reg       <= $signed(cfg_data);
                CFG_WINDOW:      window_reg      <= cfg_data[30:0];
                CFG_RANGE_LOW:   range_low_reg   <= $signed(cfg_data);
                CFG_RANGE_HIGH:  range_high_reg  <= $signed(cfg_data);
                CFG_COLOR_COUNT: color_count_reg <= cfg_data[WLR_COUNT_W-1:0];
                CFG_INVERSE:     inverse_reg     <= cfg_data[0];
                CFG_BELOW_COLOR: below_reg       <= cfg_data;
                CFG_ABOVE_COLOR: above_reg       <= cfg_data;
            endcase
        end
    end

    // Pipeline advances whenever the skid slot is free
    logic en;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: ramp ends relative to range_low, span, clamped color count
    // ------------------------------------------------------------------
    logic [XW-1:0]           cc_ext;
    logic [CW-1:0]           colors_next;
    logic signed [AW-1:0]    a_s_next;
    logic signed [AW-1:0]    a_e_next;
    logic signed [DIFFW-1:0] diff_next;

    logic                    v1_reg;
    logic [WLR_IDX_W-1:0]    idx1_reg;
    logic [CW-1:0]           colors1_reg;
    logic signed [AW-1:0]    a_s1_reg;
    logic signed [AW-1:0]    a_e1_reg;
    logic signed [DIFFW-1:0] diff1_reg;

    always_comb
    begin
        cc_ext = XW'(color_count_reg);
        priority if (cc_ext < XW'(WLR_MIN_COLORS))
            colors_next = CW'(WLR_MIN_COLORS);
        else if (cc_ext > XW'(MAX_COLORS))
            colors_next = CW'(MAX_COLORS);
        else
            colors_next = CW'(cc_ext);
    end

    assign a_s_next  = AW'($signed({level_reg, 1'b0}))
                     - AW'($signed({1'b0, window_reg}))
                     - AW'($signed({range_low_reg, 1'b0}));
    assign a_e_next  = AW'($signed({level_reg, 1'b0}))
                     + AW'($signed({1'b0, window_reg}))
                     - AW'($signed({range_low_reg, 1'b0}));
    assign diff_next = $signed({range_high_reg[31], range_high_reg})
                     - $signed({range_low_reg[31], range_low_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg    <= s_tdata;
            colors1_reg <= colors_next;
            a_s1_reg    <= a_s_next;
            a_e1_reg    <= a_e_next;
            diff1_reg   <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sign-normalize, scale by the color count
    // ------------------------------------------------------------------
    logic                    span_neg;
    logic [DIFFW-1:0]        span_mag;
    logic signed [CW:0]      c_ext;
    logic signed [CW:0]      c_mul;
    logic signed [NUMW-1:0]  num_s;
    logic signed [NUMW-1:0]  num_e;

    logic                    v2_reg;
    logic [WLR_IDX_W-1:0]    idx2_reg;
    logic [CW-1:0]           colors2_reg;
    logic                    dz2_reg;
    logic [DENW-1:0]         den2_reg;
    logic [RW-1:0]           rem_s2_reg;
    logic [RW-1:0]           rem_e2_reg;

    assign span_neg = diff1_reg[DIFFW-1];
    assign span_mag = span_neg ? (~diff1_reg + DIFFW'(1)) : diff1_reg;
    assign c_ext    = $signed({1'b0, colors1_reg});
    assign c_mul    = span_neg ? -c_ext : c_ext;
    assign num_s    = NUMW'(a_s1_reg) * NUMW'(c_mul);
    assign num_e    = NUMW'(a_e1_reg) * NUMW'(c_mul);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    // A negative numerator floors below zero and is clamped to zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx2_reg    <= idx1_reg;
            colors2_reg <= colors1_reg;
            dz2_reg     <= (diff1_reg == '0);
            den2_reg    <= {span_mag, 1'b0};
            rem_s2_reg  <= num_s[NUMW-1] ? '0 : num_s[RW-1:0];
            rem_e2_reg  <= num_e[NUMW-1] ? '0 : num_e[RW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Index division: two lanes of cells, top cell flags overflow
    // ------------------------------------------------------------------
    logic                 sl_valid [0:QW];
    logic [RW-1:0]        sl_rem   [0:QW];
    logic [DENW-1:0]      sl_div   [0:QW];
    logic [QW-1:0]        sl_quo   [0:QW];
    logic [WLR_IDX_W-1:0] sl_side  [0:QW];
    logic                 el_valid [0:QW];
    logic [RW-1:0]        el_rem   [0:QW];
    logic [DENW-1:0]      el_div   [0:QW];
    logic [QW-1:0]        el_quo   [0:QW];
    logic [ESW-1:0]       el_side  [0:QW];

    assign sl_valid[0] = v2_reg;
    assign sl_rem[0]   = rem_s2_reg;
    assign sl_div[0]   = den2_reg;
    assign sl_quo[0]   = '0;
    assign sl_side[0]  = idx2_reg;
    assign el_valid[0] = v2_reg;
    assign el_rem[0]   = rem_e2_reg;
    assign el_div[0]   = den2_reg;
    assign el_quo[0]   = '0;
    assign el_side[0]  = {dz2_reg, colors2_reg};

    for (genvar gi = 0; gi < QW; gi++)
    begin : g_idx_cell
        wlr_div_cell #(
            .RW    (RW),
            .DW    (DENW),
            .QW    (QW),
            .SHIFT (IW - gi),
            .SBW   (WLR_IDX_W)
        ) u_start (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .src_valid (sl_valid[gi]),
            .src_rem   (sl_rem[gi]),
            .src_div   (sl_div[gi]),
            .src_quo   (sl_quo[gi]),
            .src_side  (sl_side[gi]),
            .res_valid (sl_valid[gi+1]),
            .res_rem   (sl_rem[gi+1]),
            .res_div   (sl_div[gi+1]),
            .res_quo   (sl_quo[gi+1]),
            .res_side  (sl_side[gi+1])
        );

        wlr_div_cell #(
            .RW    (RW),
            .DW    (DENW),
            .QW    (QW),
            .SHIFT (IW - gi),
            .SBW   (ESW)
        ) u_end (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .src_valid (el_valid[gi]),
            .src_rem   (el_rem[gi]),
            .src_div   (el_div[gi]),
            .src_quo   (el_quo[gi]),
            .src_side  (el_side[gi]),
            .res_valid (el_valid[gi+1]),
            .res_rem   (el_rem[gi+1]),
            .res_div   (el_div[gi+1]),
            .res_quo   (el_quo[gi+1]),
            .res_side  (el_side[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: clamp indices to 0..colors-1, then raise to at least 1
    // ------------------------------------------------------------------
    function automatic logic [IW-1:0] clamp_index(
        input logic [QW-1:0] q,
        input logic [QW-1:0] top,
        input logic          zero_span
    );
        logic [QW-1:0] c;
        c = (q > top) ? top : q;
        if (zero_span)
            c = '0;
        if (c == '0)
            c = QW'(1);
        return IW'(c);
    endfunction

    logic                 dz_end;
    logic [CW-1:0]        colors_end;
    logic [QW-1:0]        top_index;

    logic                 v3_reg;
    logic [WLR_IDX_W-1:0] idx3_reg;
    logic [IW-1:0]        s3_reg;
    logic [IW-1:0]        e3_reg;

    assign dz_end     = el_side[QW][CW];
    assign colors_end = el_side[QW][CW-1:0];
    assign top_index  = QW'(colors_end) - QW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= sl_valid[QW] && el_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx3_reg <= sl_side[QW];
            s3_reg   <= clamp_index(sl_quo[QW], top_index, dz_end);
            e3_reg   <= clamp_index(el_quo[QW], top_index, dz_end);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: classify entry, set up gray numerator and divisor
    // ------------------------------------------------------------------
    logic [XIW-1:0] idx_x;
    logic [IW-1:0]  ramp_len;
    logic [IW-1:0]  ramp_pos;
    logic [IW-1:0]  ramp_t;
    sel_t           sel_next;

    logic           v4_reg;
    sel_t           sel4_reg;
    logic [GW-1:0]  gnum4_reg;
    logic [GDW-1:0] gden4_reg;

    assign idx_x    = XIW'(idx3_reg);
    assign ramp_len = e3_reg - s3_reg;
    assign ramp_pos = IW'(idx_x - XIW'(s3_reg));
    assign ramp_t   = inverse_reg ? (ramp_len - ramp_pos) : ramp_pos;

    always_comb
    begin
        priority if (idx_x >= XIW'(e3_reg))
            sel_next = SEL_HI;
        else if (idx_x < XIW'(s3_reg))
            sel_next = SEL_LO;
        else
            sel_next = SEL_RAMP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    // Gray is floor((510*t + d) / (2*d))
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel4_reg  <= sel_next;
            gnum4_reg <= GW'(ramp_t) * GW'(WLR_GRAY_SCALE) + GW'(ramp_len);
            gden4_reg <= {ramp_len, 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Gray division: one cell per quotient bit
    // ------------------------------------------------------------------
    logic                  gl_valid [0:WLR_GRAY_W];
    logic [GW-1:0]         gl_rem   [0:WLR_GRAY_W];
    logic [GDW-1:0]        gl_div   [0:WLR_GRAY_W];
    logic [WLR_GRAY_W-1:0] gl_quo   [0:WLR_GRAY_W];
    logic [1:0]            gl_side  [0:WLR_GRAY_W];

    assign gl_valid[0] = v4_reg;
    assign gl_rem[0]   = gnum4_reg;
    assign gl_div[0]   = gden4_reg;
    assign gl_quo[0]   = '0;
    assign gl_side[0]  = sel4_reg;

    for (genvar gj = 0; gj < WLR_GRAY_W; gj++)
    begin : g_gray_cell
        wlr_div_cell #(
            .RW    (GW),
            .DW    (GDW),
            .QW    (WLR_GRAY_W),
            .SHIFT (WLR_GRAY_W - 1 - gj),
            .SBW   (2)
        ) u_gray (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .src_valid (gl_valid[gj]),
            .src_rem   (gl_rem[gj]),
            .src_div   (gl_div[gj]),
            .src_quo   (gl_quo[gj]),
            .src_side  (gl_side[gj]),
            .res_valid (gl_valid[gj+1]),
            .res_rem   (gl_rem[gj+1]),
            .res_div   (gl_div[gj+1]),
            .res_quo   (gl_quo[gj+1]),
            .res_side  (gl_side[gj+1])
        );
    end

    // ------------------------------------------------------------------
    // Color select and output
    // ------------------------------------------------------------------
    sel_t                  sel_end;
    logic [WLR_GRAY_W-1:0] gray;
    logic [WLR_RGBA_W-1:0] lo_col;
    logic [WLR_RGBA_W-1:0] hi_col;
    logic [WLR_RGBA_W-1:0] rgba;

    assign sel_end = sel_t'(gl_side[WLR_GRAY_W]);
    assign gray    = gl_quo[WLR_GRAY_W];
    assign lo_col  = inverse_reg ? above_reg : below_reg;
    assign hi_col  = inverse_reg ? below_reg : above_reg;

    always_comb
    begin
        unique case (sel_end)
            SEL_LO:   rgba = lo_col;
            SEL_HI:   rgba = hi_col;
            SEL_RAMP: rgba = {WLR_OPAQUE_ALPHA, gray, gray, gray};
            default:  rgba = lo_col;
        endcase
    end

    wlr_skid #(
        .W (WLR_RGBA_W)
    ) u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (gl_valid[WLR_GRAY_W]),
        .wr_ready (en),
        .wr_data  (rgba),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // Clamped indices never reach zero
    a_index_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (s3_reg != '0) && (e3_reg != '0))
        else $error("ramp index clamped to zero");

    // Without overflow the index division leaves a remainder below its divisor, twice the span
    a_index_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sl_valid[QW] && !dz_end && !sl_quo[QW][IW] |-> sl_rem[QW] < RW'(sl_div[QW]))
        else $error("index division remainder out of range");

    // Gray division on a ramp entry leaves a remainder below its divisor
    a_gray_rem: assert property (@(posedge clk) disable iff (!rst_n)
        gl_valid[WLR_GRAY_W] && (sel_end == SEL_RAMP)
        |-> gl_rem[WLR_GRAY_W] < GW'(gl_div[WLR_GRAY_W]))
        else $error("gray division remainder out of range");

    // Input backs off only while a finished word waits at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && $past(m_tvalid))
        else $error("input stalled with no waiting output");

endmodule

// ===== design/wlr_div_cell.sv =====
// One restoring-division cell: tries one shifted divisor and passes the word on.
// Carries remainder, divisor, quotient bits and a sideband to its neighbor.
// No package dependencies.
module wlr_div_cell #(
    parameter int RW    = 16,
    parameter int DW    = 8,
    parameter int QW    = 8,
    parameter int SHIFT = 0,
    parameter int SBW   = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           src_valid,
    input  logic [RW-1:0]  src_rem,
    input  logic [DW-1:0]  src_div,
    input  logic [QW-1:0]  src_quo,
    input  logic [SBW-1:0] src_side,
    output logic           res_valid,
    output logic [RW-1:0]  res_rem,
    output logic [DW-1:0]  res_div,
    output logic [QW-1:0]  res_quo,
    output logic [SBW-1:0] res_side
);

    logic [RW-1:0]  sub_val;
    logic           fits;
    logic           valid_reg;
    logic [RW-1:0]  rem_reg;
    logic [RW-1:0]  rem_next;
    logic [DW-1:0]  div_reg;
    logic [QW-1:0]  quo_reg;
    logic [QW-1:0]  quo_next;
    logic [SBW-1:0] side_reg;

    // Try the divisor at this cell's weight, keep the bit
    assign sub_val  = RW'(src_div) << SHIFT;
    assign fits     = (src_rem >= sub_val);
    assign rem_next = fits ? (src_rem - sub_val) : src_rem;
    assign quo_next = {src_quo[QW-2:0], fits};

    // Advance valid with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= src_valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            div_reg  <= src_div;
            quo_reg  <= quo_next;
            side_reg <= src_side;
        end
    end

    assign res_valid = valid_reg;
    assign res_rem   = rem_reg;
    assign res_div   = div_reg;
    assign res_quo   = quo_reg;
    assign res_side  = side_reg;

endmodule

// ===== design/wlr_skid.sv =====
// Output register with a skid slot; parts the pipeline from the receiver.
// Ready toward the pipeline is registered. No package dependencies.
module wlr_skid #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [W-1:0] out_data_reg;
    logic [W-1:0] out_data_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic [W-1:0] skid_data_reg;
    logic [W-1:0] skid_data_next;

    assign wr_ready = !skid_valid_reg;

    // Refill the output from the skid slot first, park a word when stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || rd_ready)
        begin
            out_valid_next  = skid_valid_reg || wr_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : wr_data;
            skid_valid_next = 1'b0;
        end
        else if (wr_valid && !skid_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rd_valid = out_valid_reg;
    assign rd_data  = out_data_reg;

endmodule
